FILE: rtl/core/sppsv_pkg.sv
// Package for the segmented prime power sieve.
// Field widths, command codes, register map and default sizes.
// No dependencies.
package sppsv_pkg;

  localparam int unsigned WINDOW_LEN_DEF  = 16384;
  localparam int unsigned TABLE_DEPTH_DEF = 2048;
  localparam int unsigned WHEEL_SPAN      = 2*3*2*5*7*2*3;
  localparam int unsigned BOUND_RESET     = 4205;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SEG_W     = 26;
  localparam int unsigned OFS_W     = 14;
  localparam int unsigned PP_W      = 14;
  localparam int unsigned CNT_OUT_W = 12;
  localparam int unsigned ADDR_W    = 1;

  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIEVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [ADDR_W-1:0] REG_BOUND = 1'b0;

endpackage

FILE: rtl/core/sppsv_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data registered, available in the cycle after the read address. No dependencies.
module sppsv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/segmented_prime_power_sieve.sv
// Segmented prime power sieve, top level.
// Depends on sppsv_pkg and sppsv_ram.
//
// Commands enter on start/busy: a word is taken at a clock edge with start high
// and busy low. Each command returns one word on done_o for a single cycle.
// Build (0): clears the window scratch, then walks
//   n = 2 .. min(bound-1, WINDOW_LEN): reads the scratch for each n, and for each
//   prime power found records a table entry and writes its multiples.
// Sieve (1): init of the window memories, then per table entry a table read,
//   a remainder of the window base by the power (bit-serial unit) and the
//   marking of its entries, then a threshold pass over the window;
//   window 0 skips the first WHEEL_SPAN.
//   Cost is set by the single write port of the window memories.
// Read (2): returns the window entry at entry_offset_i; other codes answer from idle.
// The bound register sits on the APB port at byte address 0; write only while
// busy is low. After reset the divisor window memory is swept to its reset
// value with busy high. done_o cannot be held off: the word is on the result
// ports for the one cycle that done_o is high.
module segmented_prime_power_sieve #(
  parameter int unsigned WINDOW_LEN  = sppsv_pkg::WINDOW_LEN_DEF,
  parameter int unsigned TABLE_DEPTH = sppsv_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [sppsv_pkg::CMD_W-1:0]        command_i,
  input  logic [sppsv_pkg::SEG_W-1:0]        segment_index_i,
  input  logic [sppsv_pkg::OFS_W-1:0]        entry_offset_i,
  output logic                               done_o,
  output logic [sppsv_pkg::PP_W-1:0]         largest_prime_power_o,
  output logic                               marked_large_o,
  output logic [sppsv_pkg::CNT_OUT_W-1:0]    table_entries_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sppsv_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import sppsv_pkg::*;

  localparam int unsigned AW     = $clog2(WINDOW_LEN);
  localparam int unsigned JW     = AW + 2;
  localparam int unsigned NW     = AW + 2;
  localparam int unsigned TW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BASE_W = SEG_W + AW;
  localparam int unsigned PROD_W = BASE_W + 1;
  localparam int unsigned MCW    = $clog2(BASE_W + 1);
  localparam int unsigned PW2    = 2 * PP_W;
  localparam int unsigned DIV_W  = PP_W + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_B_RD   = 4'd2;
  localparam logic [3:0] S_B_CHK  = 4'd3;
  localparam logic [3:0] S_B_MARK = 4'd4;
  localparam logic [3:0] S_T_RD   = 4'd5;
  localparam logic [3:0] S_T_LD   = 4'd6;
  localparam logic [3:0] S_MOD    = 4'd7;
  localparam logic [3:0] S_MARK   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_R_RD   = 4'd10;
  localparam logic [3:0] S_R_OUT  = 4'd11;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_SIEVE = 2'd2;

  logic [3:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [NW-1:0]     n_q, n_d;
  logic [JW-1:0]     j_q, j_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [PROD_W-1:0] thr_q, thr_d;
  logic              segz_q, segz_d;
  logic [PP_W-1:0]   pp_q, pp_d;
  logic [PP_W-1:0]   p_q, p_d;
  logic [PP_W-1:0]   r_q, r_d;
  logic [BASE_W-1:0] sh_q, sh_d;
  logic [MCW-1:0]    mc_q, mc_d;
  logic              pv_q, pv_d;
  logic [AW-1:0]     pa_q, pa_d;
  logic [OFS_W-1:0]  ofs_q, ofs_d;
  logic [PP_W-1:0]   bound_q, bound_d;
  logic              done_q, done_d;
  logic [PP_W-1:0]   lpp_q, lpp_d;
  logic              mark_q, mark_d;

  logic              div_we;
  logic [AW-1:0]     div_waddr, div_raddr;
  logic [DIV_W-1:0]  div_wdata, div_rdata;
  logic              prod_we;
  logic [AW-1:0]     prod_waddr, prod_raddr;
  logic [PROD_W-1:0] prod_wdata, prod_rdata;
  logic              tab_we;
  logic [TW-1:0]     tab_waddr, tab_raddr;
  logic [PW2-1:0]    tab_wdata, tab_rdata;

  logic [PP_W-1:0]   b_d;
  logic [PP_W-1:0]   b_pr;
  logic              b_ispp;
  logic [PP_W:0]     m_t, m_rn;
  logic [PROD_W-1:0] mul_prod;
  logic              apb_wr;

  assign b_d    = (div_rdata[PP_W-1:0] == '0) ? PP_W'(1) : div_rdata[PP_W-1:0];
  assign b_pr   = prod_rdata[PP_W-1:0];
  assign b_ispp = (b_d == PP_W'(1)) || ((PW2'(b_d) * PW2'(b_pr)) == PW2'(n_q));
  assign m_t    = {r_q, sh_q[BASE_W-1]};
  assign m_rn   = (m_t >= {1'b0, pp_q}) ? (m_t - {1'b0, pp_q}) : m_t;
  assign mul_prod = PROD_W'(prod_rdata * PROD_W'(p_q));
  assign apb_wr = psel && penable && pwrite && pready;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ptr_d   = ptr_q;
    n_d     = n_q;
    j_d     = j_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    thr_d   = thr_q;
    segz_d  = segz_q;
    pp_d    = pp_q;
    p_d     = p_q;
    r_d     = r_q;
    sh_d    = sh_q;
    mc_d    = mc_q;
    pv_d    = 1'b0;
    pa_d    = pa_q;
    ofs_d   = ofs_q;
    done_d  = 1'b0;
    lpp_d   = lpp_q;
    mark_d  = mark_q;
    bound_d = bound_q;

    div_we     = 1'b0;
    div_waddr  = ptr_q;
    div_wdata  = {1'b0, PP_W'(1)};
    div_raddr  = '0;
    prod_we    = 1'b0;
    prod_waddr = ptr_q;
    prod_wdata = PROD_W'(1);
    prod_raddr = '0;
    tab_we     = 1'b0;
    tab_waddr  = cnt_q[TW-1:0];
    tab_wdata  = {p_q, n_q[PP_W-1:0]};
    tab_raddr  = i_q[TW-1:0];

    if (apb_wr && (paddr == REG_BOUND)) begin
      bound_d = pwdata[PP_W-1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (command_i)
            CMD_BUILD: begin
              op_d    = OP_BUILD;
              ptr_d   = '0;
              cnt_d   = '0;
              state_d = S_INIT;
            end
            CMD_SIEVE: begin
              op_d    = OP_SIEVE;
              ptr_d   = '0;
              base_d  = BASE_W'(segment_index_i) * BASE_W'(WINDOW_LEN);
              segz_d  = (segment_index_i == '0);
              thr_d   = (segment_index_i == '0) ? PROD_W'(WHEEL_SPAN)
                        : PROD_W'(BASE_W'(segment_index_i) * BASE_W'(WINDOW_LEN));
              state_d = S_INIT;
            end
            CMD_READ: begin
              ofs_d   = entry_offset_i;
              state_d = S_R_RD;
            end
            default: begin
              lpp_d  = '0;
              mark_d = 1'b0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_INIT: begin
        div_we  = 1'b1;
        prod_we = (op_q == OP_SIEVE);
        ptr_d   = ptr_q + AW'(1);
        if (ptr_q == AW'(WINDOW_LEN - 1)) begin
          unique case (op_q)
            OP_BUILD: begin
              n_d     = NW'(2);
              state_d = S_B_RD;
            end
            OP_SIEVE: begin
              i_d     = '0;
              state_d = S_T_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_B_RD: begin
        if ((n_q < NW'(bound_q)) && (n_q <= NW'(WINDOW_LEN))) begin
          div_raddr  = AW'(n_q - NW'(1));
          prod_raddr = AW'(n_q - NW'(1));
          state_d    = S_B_CHK;
        end else begin
          lpp_d   = '0;
          mark_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_B_CHK: begin
        if (b_ispp) begin
          p_d = (b_d == PP_W'(1)) ? n_q[PP_W-1:0] : b_pr;
          if (cnt_q < CW'(TABLE_DEPTH)) begin
            tab_we    = 1'b1;
            tab_wdata = {((b_d == PP_W'(1)) ? n_q[PP_W-1:0] : b_pr), n_q[PP_W-1:0]};
            cnt_d     = cnt_q + CW'(1);
          end
          j_d     = JW'(n_q - NW'(1));
          state_d = S_B_MARK;
        end else begin
          n_d     = n_q + NW'(1);
          state_d = S_B_RD;
        end
      end
      S_B_MARK: begin
        if (j_q < JW'(WINDOW_LEN)) begin
          div_we     = 1'b1;
          div_waddr  = AW'(j_q);
          div_wdata  = {1'b0, n_q[PP_W-1:0]};
          prod_we    = 1'b1;
          prod_waddr = AW'(j_q);
          prod_wdata = PROD_W'(p_q);
          j_d        = j_q + JW'(n_q);
        end else begin
          n_d     = n_q + NW'(1);
          state_d = S_B_RD;
        end
      end
      S_T_RD: begin
        if (i_q == cnt_q) begin
          j_d     = segz_q ? JW'(WHEEL_SPAN) : '0;
          state_d = S_FIN;
        end else begin
          state_d = S_T_LD;
        end
      end
      S_T_LD: begin
        pp_d = tab_rdata[PP_W-1:0];
        p_d  = tab_rdata[PW2-1:PP_W];
        if (tab_rdata[PP_W-1:0] == '0) begin
          i_d     = i_q + CW'(1);
          state_d = S_T_RD;
        end else begin
          r_d     = '0;
          sh_d    = base_q;
          mc_d    = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        r_d  = m_rn[PP_W-1:0];
        sh_d = sh_q << 1;
        mc_d = mc_q + MCW'(1);
        if (mc_q == MCW'(BASE_W - 1)) begin
          j_d     = JW'(pp_q) - JW'(1) - JW'(m_rn[PP_W-1:0]);
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        if (pv_q) begin
          prod_we    = 1'b1;
          prod_waddr = pa_q;
          prod_wdata = mul_prod;
          div_we     = 1'b1;
          div_waddr  = pa_q;
          div_wdata  = {1'b0, pp_q};
        end
        if (j_q < JW'(WINDOW_LEN)) begin
          prod_raddr = AW'(j_q);
          pv_d       = 1'b1;
          pa_d       = AW'(j_q);
          j_d        = j_q + JW'(pp_q);
        end else if (!pv_q) begin
          i_d     = i_q + CW'(1);
          state_d = S_T_RD;
        end
      end
      S_FIN: begin
        if (pv_q && (prod_rdata <= thr_q)) begin
          div_we    = 1'b1;
          div_waddr = pa_q;
          div_wdata = {1'b1, bound_q};
        end
        if (j_q < JW'(WINDOW_LEN)) begin
          prod_raddr = AW'(j_q);
          pv_d       = 1'b1;
          pa_d       = AW'(j_q);
          j_d        = j_q + JW'(1);
        end else if (!pv_q) begin
          lpp_d   = '0;
          mark_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_R_RD: begin
        if (32'(ofs_q) < WINDOW_LEN) begin
          div_raddr = AW'(ofs_q);
          state_d   = S_R_OUT;
        end else begin
          lpp_d   = '0;
          mark_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_R_OUT: begin
        lpp_d   = div_rdata[PP_W-1:0];
        mark_d  = div_rdata[PP_W];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= OP_CLEAR;
      ptr_q   <= '0;
      n_q     <= '0;
      j_q     <= '0;
      i_q     <= '0;
      cnt_q   <= '0;
      base_q  <= '0;
      thr_q   <= '0;
      segz_q  <= 1'b1;
      pp_q    <= '0;
      p_q     <= '0;
      r_q     <= '0;
      sh_q    <= '0;
      mc_q    <= '0;
      pv_q    <= 1'b0;
      pa_q    <= '0;
      ofs_q   <= '0;
      bound_q <= PP_W'(BOUND_RESET);
      done_q  <= 1'b0;
      lpp_q   <= '0;
      mark_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ptr_q   <= ptr_d;
      n_q     <= n_d;
      j_q     <= j_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      thr_q   <= thr_d;
      segz_q  <= segz_d;
      pp_q    <= pp_d;
      p_q     <= p_d;
      r_q     <= r_d;
      sh_q    <= sh_d;
      mc_q    <= mc_d;
      pv_q    <= pv_d;
      pa_q    <= pa_d;
      ofs_q   <= ofs_d;
      bound_q <= bound_d;
      done_q  <= done_d;
      lpp_q   <= lpp_d;
      mark_q  <= mark_d;
    end
  end

  sppsv_ram #(.WIDTH(DIV_W), .DEPTH(WINDOW_LEN)) u_div_ram (
    .clk_i  (clk_i),
    .we_i   (div_we),
    .waddr_i(div_waddr),
    .wdata_i(div_wdata),
    .raddr_i(div_raddr),
    .rdata_o(div_rdata)
  );

  sppsv_ram #(.WIDTH(PROD_W), .DEPTH(WINDOW_LEN)) u_prod_ram (
    .clk_i  (clk_i),
    .we_i   (prod_we),
    .waddr_i(prod_waddr),
    .wdata_i(prod_wdata),
    .raddr_i(prod_raddr),
    .rdata_o(prod_rdata)
  );

  sppsv_ram #(.WIDTH(PW2), .DEPTH(TABLE_DEPTH)) u_tab_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_waddr),
    .wdata_i(tab_wdata),
    .raddr_i(tab_raddr),
    .rdata_o(tab_rdata)
  );

  assign busy                  = (state_q != S_IDLE);
  assign done_o                = done_q;
  assign largest_prime_power_o = lpp_q;
  assign marked_large_o        = mark_q;
  assign table_entries_o       = CNT_OUT_W'(cnt_q);
  assign pready                = 1'b1;
  assign prdata                = (paddr == REG_BOUND) ? 32'(bound_q) : 32'd0;

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(done_o) |-> $past(busy) || $past(start))
    else $error("result word without a command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("table count past depth");

  a_pipe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == S_MARK) || (state_q == S_FIN))
    else $error("write pipeline active outside marking");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted command dropped");

endmodule

FILE: test/segmented_prime_power_sieve_check.sv
`timescale 1ns / 100ps
// Checker for the segmented prime power sieve: tracks the bound register on the
// APB port, predicts every result word and compares it. Depends on sppsv_pkg.
module segmented_prime_power_sieve_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic [sppsv_pkg::CMD_W-1:0]     command_i,
  input  logic [sppsv_pkg::SEG_W-1:0]     segment_index_i,
  input  logic [sppsv_pkg::OFS_W-1:0]     entry_offset_i,
  input  logic                            done_o,
  input  logic [sppsv_pkg::PP_W-1:0]      largest_prime_power_o,
  input  logic                            marked_large_o,
  input  logic [sppsv_pkg::CNT_OUT_W-1:0] table_entries_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [sppsv_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output int                              fail_count,
  output int                              pending
);

  import sppsv_pkg::*;

  localparam int unsigned WLEN  = WINDOW_LEN_DEF;
  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic [PP_W-1:0]      power;
    logic                 marked;
    logic [CNT_OUT_W-1:0] entries;
  } sieve_word_t;

  sieve_word_t       expected_words[$];
  logic [PP_W-1:0]   win_div[WLEN];
  bit                win_mark[WLEN];
  longint unsigned   win_prod[WLEN];
  logic [PP_W-1:0]   power_tab[DEPTH];
  logic [PP_W-1:0]   prime_tab[DEPTH];
  int unsigned       tab_count;
  logic [PP_W-1:0]   bound;

  task automatic clear_window();
    for (int j = 0; j < WLEN; j++) begin
      win_div[j]  = 1;
      win_mark[j] = 0;
    end
  endtask

  task automatic build_powers();
    int unsigned d, p;
    tab_count = 0;
    clear_window();
    for (int unsigned n = 2; n < bound && n <= WLEN; n++) begin
      d = win_div[n-1];
      if (d == 0) d = 1;
      p = n / d;
      if (d == 1 || (d % p) == 0) begin
        if (tab_count < DEPTH) begin
          power_tab[tab_count] = n[PP_W-1:0];
          prime_tab[tab_count] = p[PP_W-1:0];
          tab_count++;
        end
        for (int unsigned j = n - 1; j < WLEN; j += n) win_div[j] = n[PP_W-1:0];
      end
    end
  endtask

  task automatic sieve_segment(input logic [SEG_W-1:0] seg);
    longint unsigned base, limit;
    int unsigned pp, first;
    base = longint'(seg) * WLEN;
    for (int j = 0; j < WLEN; j++) begin
      win_div[j]  = 1;
      win_prod[j] = 1;
      win_mark[j] = 0;
    end
    for (int unsigned i = 0; i < tab_count; i++) begin
      pp = power_tab[i];
      if (pp != 0) begin
        first = pp - 1 - int'(base % pp);
        for (int unsigned j = first; j < WLEN; j += pp) begin
          win_div[j]  = pp[PP_W-1:0];
          win_prod[j] = win_prod[j] * prime_tab[i];
        end
      end
    end
    limit = (seg != 0) ? base : WHEEL_SPAN;
    for (int unsigned j = (seg != 0) ? 0 : WHEEL_SPAN; j < WLEN; j++) begin
      if (win_prod[j] <= limit) begin
        win_div[j]  = bound;
        win_mark[j] = 1;
      end
    end
  endtask

  assign pending = expected_words.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sieve_word_t w, got;
    if (!rst_ni) begin
      clear_window();
      tab_count  = 0;
      bound      = PP_W'(BOUND_RESET);
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_BOUND) bound = pwdata[PP_W-1:0];
      if (start && !busy) begin
        w = '0;
        case (command_i)
          CMD_BUILD: build_powers();
          CMD_SIEVE: sieve_segment(segment_index_i);
          CMD_READ: begin
            w.power  = win_div[entry_offset_i];
            w.marked = win_mark[entry_offset_i];
          end
          default: ;
        endcase
        w.entries = tab_count[CNT_OUT_W-1:0];
        expected_words.push_back(w);
      end
      if (done_o) begin
        got = '{largest_prime_power_o, marked_large_o, table_entries_o};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", got);
        end else begin
          w = expected_words.pop_front();
          if (got !== w) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected pp=%0d large=%0d entries=%0d,",
                        " got pp=%0d large=%0d entries=%0d"},
                       w.power, w.marked, w.entries, got.power, got.marked, got.entries);
          end
        end
      end
    end
  end

endmodule

FILE: test/segmented_prime_power_sieve_test.sv
`timescale 1ns / 100ps
// Testbench top for the segmented prime power sieve: drives commands and APB
// writes, and gives the verdict. Depends on sppsv_pkg, the sieve top and the checker module.
module segmented_prime_power_sieve_test;
  import sppsv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint unsigned  CYCLE_LIMIT = 40_000_000;

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 start = 0;
  logic                 busy;
  logic [CMD_W-1:0]     command_i = CMD_READ;
  logic [SEG_W-1:0]     segment_index_i = 0;
  logic [OFS_W-1:0]     entry_offset_i = 0;
  logic                 done_o;
  logic [PP_W-1:0]      largest_prime_power_o;
  logic                 marked_large_o;
  logic [CNT_OUT_W-1:0] table_entries_o;
  logic                 psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0]    paddr = REG_BOUND;
  logic [31:0]          pwdata = 0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   fail_count, pending;
  int                   words_sent = 0, heavy_sent = 0;
  longint unsigned      cycles = 0;

  segmented_prime_power_sieve i_dut (.*);

  segmented_prime_power_sieve_check i_check (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SEG_W-1:0] seg,
                           input logic [OFS_W-1:0] ofs);
    int gap;
    gap = $urandom_range(4);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1;
    command_i       <= cmd;
    segment_index_i <= seg;
    entry_offset_i  <= ofs;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    words_sent++;
    if (cmd == CMD_BUILD || cmd == CMD_SIEVE) heavy_sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_bound(input logic [PP_W-1:0] value);
    drain();
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= REG_BOUND;
    pwdata  <= ($urandom() & 32'hFFFF_C000) | 32'(value);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [PP_W-1:0] value, input int reads);
    int r;
    logic [SEG_W-1:0] seg;
    write_bound(value);
    send_word(CMD_BUILD, SEG_W'($urandom()), OFS_W'($urandom()));
    r = $urandom_range(2);
    seg = (r == 0) ? '0 : (r == 1) ? {SEG_W{1'b1}} : SEG_W'($urandom());
    send_word(CMD_SIEVE, seg, OFS_W'($urandom()));
    for (int i = 0; i < reads; i++) begin
      r = $urandom_range(199);
      if (r == 0) send_word(CMD_SIEVE, SEG_W'($urandom()), OFS_W'($urandom()));
      else if (r == 1) send_word(CMD_BUILD, SEG_W'($urandom()), OFS_W'($urandom()));
      else if (r < 10) send_word(CMD_UNUSED, SEG_W'($urandom()), OFS_W'($urandom()));
      else if (r < 30)
        send_word(CMD_READ, SEG_W'($urandom()), OFS_W'(WHEEL_SPAN - 4 + $urandom_range(8)));
      else send_word(CMD_READ, SEG_W'($urandom()), OFS_W'($urandom()));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed part, reset bound
    send_word(CMD_READ, 0, 0);
    send_word(CMD_READ, 0, {OFS_W{1'b1}});
    send_word(CMD_UNUSED, {SEG_W{1'b1}}, {OFS_W{1'b1}});
    send_word(CMD_SIEVE, 5, 0);
    send_word(CMD_READ, 0, 100);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_READ, 0, 0);
    send_word(CMD_READ, 0, 3);
    send_word(CMD_READ, 0, 4095);
    send_word(CMD_SIEVE, 0, 0);
    send_word(CMD_READ, 0, OFS_W'(WHEEL_SPAN - 1));
    send_word(CMD_READ, 0, OFS_W'(WHEEL_SPAN));
    send_word(CMD_READ, 0, {OFS_W{1'b1}});
    send_word(CMD_SIEVE, {SEG_W{1'b1}}, 0);
    send_word(CMD_READ, 0, 0);
    send_word(CMD_READ, 0, {OFS_W{1'b1}});
    // empty table, then one built with the largest bound
    write_bound(2);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_SIEVE, 1, 0);
    send_word(CMD_READ, 0, 7);
    write_bound(16383);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_READ, 0, 16380);
    send_word(CMD_SIEVE, 3, 0);
    send_word(CMD_READ, 0, 1);
    // random part
    random_phase(3, 100);
    random_phase(60, 110);
    random_phase(PP_W'(BOUND_RESET), 110);
    random_phase(16383, 100);
    random_phase(PP_W'($urandom_range(16383, 2)), 110);
    drain();
    repeat (50) @(posedge clk_i);
    $display("sent %0d command words (%0d build/sieve) over bounds 2..16383, windows 0..max",
             words_sent, heavy_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: segmented_prime_power_sieve.f
rtl/core/sppsv_pkg.sv
rtl/core/sppsv_ram.sv
rtl/core/segmented_prime_power_sieve.sv
test/segmented_prime_power_sieve_check.sv
test/segmented_prime_power_sieve_test.sv
